FILE: rtl/lph_pkg.sv
package lph_pkg;

    // Slot status codes.
    typedef enum logic [1:0] {
        ST_NEVER   = 2'd0,
        ST_USED    = 2'd1,
        ST_REMOVED = 2'd2
    } t_slot_st;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_FULL     = 2'd1;
    localparam logic [1:0] RS_NOTFOUND = 2'd2;
    localparam logic [1:0] RS_EMPTY    = 2'd3;

    localparam int unsigned HASH_MULT = 37;
    localparam int unsigned KEY_W     = 64;
    localparam int unsigned SIZE_W    = 11;
    localparam int unsigned SLOT_W    = 10;
    localparam int unsigned CFG_SIZE  = 0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture request and size
        logic hash_step;  // fold one character
        logic hash_red;   // one restoring reduction step
        logic probe_rd;   // issue status/key read at probe index
        logic advance;    // step the probe index
        logic wr_used;    // write key and mark slot used
        logic wr_removed; // mark slot removed
        logic clr_step;   // write never-used at clear index
        logic clr_start;  // restart clear sweep
        logic res_cap;    // capture the result slot
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_empty;
        logic full;
        logic hash_done;
        logic red_done;
        logic rd_never;
        logic rd_used;
        logic rd_match;
        logic wrapped;
        logic clr_done;
    } t_sts;

endpackage

FILE: rtl/lph_datapath.sv
module lph_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_CHARS   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lph_pkg::t_cmd         i_cmd,
    output lph_pkg::t_sts         o_sts,
    input  logic [1:0]            i_operation,
    input  logic [63:0]           i_key,
    input  logic [10:0]           i_size_reg,
    output logic [1:0]            o_op,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_idx
);
    import lph_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HW = IW + 8;

    // Memories: slot status and slot keys.
    logic [1:0]        r_st_mem  [TABLE_DEPTH];
    logic [KEY_W-1:0]  r_key_mem [TABLE_DEPTH];
    logic [1:0]        r_st_rd;
    logic [KEY_W-1:0]  r_key_rd;

    logic [KEY_W-1:0]  r_key, n_key_norm;
    logic [1:0]        r_op;
    logic [CW-1:0]     r_size, n_size;
    logic [IW-1:0]     r_idx, r_start, r_clr, r_res_idx;
    logic [CW-1:0]     r_occ;
    logic [3:0]        r_ci;
    logic [3:0]        r_rsh;
    logic [HW-1:0]     r_h;
    logic              w_hash_fin;

    // Normalize: keep bytes until first zero, at most KEY_CHARS.
    always_comb begin
        logic stop;
        n_key_norm = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= KEY_CHARS || i_key[8*i +: 8] == 8'd0) stop = 1'b1;
            if (!stop) n_key_norm[8*i +: 8] = i_key[8*i +: 8];
        end
    end

    // Saturate the size into [2, TABLE_DEPTH].
    always_comb begin
        if (i_size_reg < 11'd2) n_size = CW'(2);
        else if ({21'd0, i_size_reg} > 32'(TABLE_DEPTH)) n_size = CW'(TABLE_DEPTH);
        else n_size = CW'(i_size_reg);
    end

    logic [7:0] w_char;
    logic [HW-1:0] w_sz_ext, w_sz_sh, w_sub;
    assign w_char   = r_key[{r_ci[2:0], 3'b000} +: 8];
    assign w_sz_ext = HW'(r_size);
    // The fold h*37 + c stays below 256 times the size, so eight restoring steps
    // with the size shifted left by 7 down to 0 bring it below the size.
    assign w_sz_sh  = w_sz_ext << (r_rsh - 4'd1);
    assign w_sub    = r_h - w_sz_sh;

    logic [HW+6:0] w_fold_wide;
    assign w_fold_wide = (HW+7)'(r_h) * (HW+7)'(HASH_MULT) + (HW+7)'(w_char);

    // Shared registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr <= '0;
                r_occ <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.wr_used) r_occ <= r_occ + CW'(1);
            if (i_cmd.wr_removed && r_occ != '0) r_occ <= r_occ - CW'(1);
        end
        if (i_cmd.load) begin
            r_key  <= n_key_norm;
            r_op   <= i_operation;
            r_size <= n_size;
            r_h    <= '0;
            r_ci   <= '0;
            r_rsh  <= '0;
        end else if (i_cmd.hash_step) begin
            r_h   <= w_fold_wide[HW-1:0];
            r_ci  <= r_ci + 4'd1;
            r_rsh <= 4'd8;
        end else if (i_cmd.hash_red) begin
            if (r_h >= w_sz_sh) r_h <= w_sub;
            r_rsh <= r_rsh - 4'd1;
        end
        if (i_cmd.probe_rd && w_hash_fin) begin
            r_idx   <= r_h[IW-1:0];
            r_start <= r_h[IW-1:0];
        end else if (i_cmd.advance) begin
            if (CW'(r_idx) + CW'(1) >= r_size) r_idx <= '0;
            else r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.res_cap) r_res_idx <= r_idx;
    end

    // Hash is finished once every character has been folded and reduced.
    assign w_hash_fin = o_sts.hash_done && o_sts.red_done;

    // Memory access.
    logic [IW-1:0] w_rd_addr;
    assign w_rd_addr = (i_cmd.probe_rd && w_hash_fin) ? r_h[IW-1:0] :
                       (i_cmd.advance ? ((CW'(r_idx) + CW'(1) >= r_size) ? '0
                                         : r_idx + IW'(1)) : r_idx);
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) r_st_mem[r_clr] <= ST_NEVER;
        else if (i_cmd.wr_used) r_st_mem[r_idx] <= ST_USED;
        else if (i_cmd.wr_removed) r_st_mem[r_idx] <= ST_REMOVED;
        if (i_cmd.wr_used) r_key_mem[r_idx] <= r_key;
        r_st_rd  <= r_st_mem[w_rd_addr];
        r_key_rd <= r_key_mem[w_rd_addr];
    end

    logic w_more_chars;
    assign w_more_chars = (r_ci < 4'd8) && (w_char != 8'd0);

    always_comb begin
        o_sts.key_empty = (r_key == '0);
        o_sts.full      = (r_occ + CW'(1) >= r_size);
        o_sts.hash_done = !w_more_chars;
        o_sts.red_done  = (r_rsh == 4'd0);
        o_sts.rd_never  = (r_st_rd == ST_NEVER);
        o_sts.rd_used   = (r_st_rd == ST_USED);
        o_sts.rd_match  = (r_key_rd == r_key);
        o_sts.wrapped   = ((CW'(r_idx) + CW'(1) >= r_size) ? IW'(0) : r_idx + IW'(1))
                          == r_start;
        o_sts.clr_done  = (32'(r_clr) == TABLE_DEPTH - 1);
    end

    assign o_op  = r_op;
    assign o_idx = r_res_idx;

endmodule

FILE: rtl/lph_ctrl.sv
module lph_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  logic           i_cfg_wr,
    input  lph_pkg::t_sts  i_sts,
    input  logic [1:0]     i_op,
    output lph_pkg::t_cmd  o_cmd,
    output logic [1:0]     o_status,
    output logic           o_found,
    output logic           o_take_slot
);
    import lph_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_HASH, S_RED, S_ISSUE, S_WAIT,
        S_EVAL, S_WRITE, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic [1:0] r_status, n_status, r_res_status, n_res_status;
    logic   r_found, n_found, r_take, n_take;
    logic   r_res_found, n_res_found, r_res_take, n_res_take;

    // Next-state and command logic.
    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        n_status = r_status;
        n_found = r_found;
        n_take = r_take;
        n_res_status = r_res_status;
        n_res_found = r_res_found;
        n_res_take = r_res_take;
        o_cmd = '0;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_found = 1'b0;
                n_take = 1'b0;
                if (i_sts.key_empty) begin
                    n_status = RS_EMPTY;
                    n_state = S_OUT;
                end else if (i_op == OP_INSERT && i_sts.full) begin
                    n_status = RS_FULL;
                    n_state = S_OUT;
                end else begin
                    n_status = RS_OK;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (!i_sts.red_done) begin
                    o_cmd.hash_red = 1'b1;
                end else if (!i_sts.hash_done) begin
                    o_cmd.hash_step = 1'b1;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_RED: n_state = S_HASH;
            S_ISSUE: begin
                o_cmd.probe_rd = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: n_state = S_EVAL;
            S_EVAL: begin
                if (i_op == OP_INSERT) begin
                    if (!i_sts.rd_used || i_sts.wrapped) begin
                        n_state = S_WRITE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state = S_WAIT;
                    end
                end else if (i_sts.rd_never) begin
                    n_status = (i_op == OP_REMOVE) ? RS_NOTFOUND : RS_OK;
                    n_state = S_OUT;
                end else if (i_sts.rd_used && i_sts.rd_match) begin
                    n_take = 1'b1;
                    if (i_op == OP_REMOVE) begin
                        o_cmd.wr_removed = 1'b1;
                    end else begin
                        n_found = 1'b1;
                    end
                    n_state = S_OUT;
                end else if (i_sts.wrapped) begin
                    n_status = (i_op == OP_REMOVE) ? RS_NOTFOUND : RS_OK;
                    n_state = S_OUT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WRITE: begin
                o_cmd.wr_used = 1'b1;
                n_take = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // Move the answer into the output register once it is free.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.res_cap = 1'b1;
                    n_out_valid = 1'b1;
                    n_res_status = r_status;
                    n_res_found = r_found;
                    n_res_take = r_take;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_wr) begin
            o_cmd = '0;
            o_cmd.clr_start = 1'b1;
            n_state = S_CLEAR;
        end
    end

    // State and registered result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_out_valid  <= 1'b0;
            r_status     <= RS_OK;
            r_found      <= 1'b0;
            r_take       <= 1'b0;
            r_res_status <= RS_OK;
            r_res_found  <= 1'b0;
            r_res_take   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_status     <= n_status;
            r_found      <= n_found;
            r_take       <= n_take;
            r_res_status <= n_res_status;
            r_res_found  <= n_res_found;
            r_res_take   <= n_res_take;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_res_status;
    assign o_found     = r_res_found;
    assign o_take_slot = r_res_take;

    // A result is raised only when leaving the result state.
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside result state");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res_found |-> r_res_status == RS_OK && r_res_take)
        else $error("found without ok status and slot");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("request loaded while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_res_status)
            && $stable(r_res_found) && $stable(r_res_take))
        else $error("stalled result changed");
endmodule

FILE: rtl/linear_probe_hash_table.sv
// Flow: each key character takes one fold and eight reduction steps; each probed slot passes
// through S_WAIT and S_EVAL, and an insert adds S_WRITE. Empty keys and full inserts skip the hash.
// One request is in work at a time; the next one can be taken as soon as the result
// is raised, even while that result still waits for the receiver.
// Reset (synchronous, active low) sets size 1024 and sweeps the status memory to never-used;
// a table_size write starts the same sweep. No request is taken meanwhile.
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_CHARS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_key,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [9:0]  o_slot,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lph_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    t_cmd w_cmd;
    t_sts w_sts;
    logic [1:0] w_op;
    logic [IW-1:0] w_idx;
    logic w_take, w_cfg_wr;
    logic [10:0] r_size;

    // Configuration register write.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && paddr == 2'(CFG_SIZE * 4);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_size <= 11'd1024;
        else if (w_cfg_wr) r_size <= pwdata[10:0];
    end
    assign prdata = (paddr == 2'(CFG_SIZE * 4)) ? {21'd0, r_size} : 32'd0;

    lph_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .o_in_stall(o_stall),
        .o_out_valid(o_valid), .i_out_stall(i_stall),
        .i_cfg_wr(w_cfg_wr), .i_sts(w_sts), .i_op(w_op),
        .o_cmd(w_cmd), .o_status(o_status), .o_found(o_found),
        .o_take_slot(w_take)
    );

    lph_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_CHARS(KEY_CHARS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_operation, .i_key, .i_size_reg(r_size),
        .o_op(w_op), .o_idx(w_idx)
    );

    logic [31:0] w_idx32;
    assign w_idx32 = 32'(w_idx);
    assign o_slot  = w_take ? w_idx32[9:0] : 10'd0;
endmodule

FILE: bench/linear_probe_hash_table_tb.sv
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
    import lph_pkg::*;

    // The spare operation code behaves as a lookup.
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] key;
    } t_req;

    typedef struct {
        logic [1:0] status;
        logic       found;
        logic [9:0] slot;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_operation;
    logic [63:0] i_key;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic        o_found;
    logic [9:0]  o_slot;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    linear_probe_hash_table uut (.*);

    // Shadow copy of the table.
    t_slot_st    shadow_st [1024];
    logic [63:0] shadow_key [1024];
    int unsigned shadow_occ;
    int unsigned shadow_size;

    t_req    pending_reqs[$];
    t_answer expected_answers[$];
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_count;
    int      fail_count;
    int      accepted_count;
    int      checked_count;

    // Clock and reset.
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] normalize_key(logic [63:0] k);
        logic [63:0] r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 0) break;
            r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic int unsigned hash_of(logic [63:0] k, int unsigned size);
        int unsigned h;
        h = 0;
        for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 0) break;
            h = (h * HASH_MULT + k[8*i +: 8]) % size;
        end
        return h;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < 1024; i++) begin
            shadow_st[i] = ST_NEVER;
            shadow_key[i] = 0;
        end
        shadow_occ = 0;
    endfunction

    // Apply one request to the shadow table and queue its answer.
    function automatic void predict_answer(logic [1:0] op, logic [63:0] raw_key);
        logic [63:0] k;
        int unsigned size;
        int unsigned idx;
        logic        hit;
        t_answer     a;
        k = normalize_key(raw_key);
        size = shadow_size < 2 ? 2 : (shadow_size > 1024 ? 1024 : shadow_size);
        a.status = RS_OK;
        a.found = 0;
        a.slot = 0;
        hit = 0;
        if (k == 0) begin
            a.status = RS_EMPTY;
        end else if (op == OP_INSERT) begin
            if (shadow_occ + 1 >= size) begin
                a.status = RS_FULL;
            end else begin
                idx = hash_of(k, size);
                for (int n = 0; n < size; n++) begin
                    if (shadow_st[idx] != ST_USED) break;
                    idx = (idx + 1) % size;
                end
                shadow_st[idx] = ST_USED;
                shadow_key[idx] = k;
                shadow_occ++;
                a.slot = idx[9:0];
            end
        end else begin
            idx = hash_of(k, size);
            for (int n = 0; n < size; n++) begin
                if (shadow_st[idx] == ST_NEVER) break;
                if (shadow_st[idx] == ST_USED && shadow_key[idx] == k) begin
                    hit = 1;
                    break;
                end
                idx = (idx + 1) % size;
            end
            if (op == OP_REMOVE) begin
                if (hit) begin
                    shadow_st[idx] = ST_REMOVED;
                    if (shadow_occ > 0) shadow_occ--;
                    a.slot = idx[9:0];
                end else begin
                    a.status = RS_NOTFOUND;
                end
            end else if (hit) begin
                a.found = 1;
                a.slot = idx[9:0];
            end
        end
        expected_answers.push_back(a);
    endfunction

    // Request driver: predicts on acceptance, then offers the next pending request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                predict_answer(i_operation, i_key);
                accepted_count++;
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_req r;
                r = pending_reqs.pop_front();
                i_valid <= 1;
                i_operation <= r.op;
                i_key <= r.key;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Receiver stall, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected result: status %0d found %0d slot %0d",
                       o_status, o_found, o_slot);
                fail_count++;
            end else begin
                t_answer a;
                a = expected_answers.pop_front();
                checked_count++;
                if (o_status !== a.status) begin
                    $error("status: expected %0d, got %0d", a.status, o_status);
                    fail_count++;
                end
                if (o_found !== a.found) begin
                    $error("found: expected %0d, got %0d", a.found, o_found);
                    fail_count++;
                end
                if (o_slot !== a.slot) begin
                    $error("slot: expected %0d, got %0d", a.slot, o_slot);
                    fail_count++;
                end
            end
        end
    end

    // Run limit.
    initial begin
        #400ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_table_size(int unsigned value);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 2'(CFG_SIZE * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        shadow_size = value & 11'h7FF;
        clear_shadow();
    endtask

    // Wait until every request has been answered, then let the block settle.
    task automatic drain();
        wait (pending_reqs.size() == 0 && !i_valid && expected_answers.size() == 0);
        repeat (2200) @(posedge i_clk);
    endtask

    task automatic add_req(logic [1:0] op, logic [63:0] k);
        t_req r;
        r.op = op;
        r.key = k;
        pending_reqs.push_back(r);
    endtask

    // Short keys over a small alphabet make collisions and repeats common.
    function automatic logic [63:0] random_key(int letters);
        logic [63:0] k;
        int          len;
        k = 0;
        case ($urandom_range(19))
            0: begin
                k = {$urandom, $urandom};
                k[7:0] = 0;
            end
            1, 2: k = {$urandom, $urandom};
            default: begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    k[8*i +: 8] = 8'(8'h61 + $urandom_range(letters - 1));
                // Garbage after the terminating zero byte.
                if ($urandom_range(3) == 0) k = k | ({$urandom, $urandom} << (8 * (len + 1)));
            end
        endcase
        return k;
    endfunction

    function automatic logic [1:0] random_op();
        int p;
        p = $urandom_range(99);
        if (p < 45) return OP_INSERT;
        if (p < 70) return OP_REMOVE;
        if (p < 95) return OP_LOOKUP;
        return OP_SPARE;
    endfunction

    int unsigned phase_sizes[7] = '{2, 5, 13, 64, 1024, 0, 2047};
    int          phase_idle[7]  = '{0, 72, 0, 19, 0, 72, 19};
    int          phase_stall[7] = '{0, 0, 72, 19, 0, 0, 19};

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_operation = OP_INSERT;
        i_key = 0;
        i_stall = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_count = 0;
        fail_count = 0;
        accepted_count = 0;
        checked_count = 0;
        shadow_size = 1024;
        clear_shadow();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: key extremes and the unused operation at reset size.
        add_req(OP_LOOKUP, 64'h0);
        add_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FF00);
        add_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(OP_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(OP_INSERT, 64'h5555_0000_0000_6162);
        add_req(OP_LOOKUP, 64'h0000_0000_0000_6162);
        add_req(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA);
        add_req(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // Directed: tiny table with full, duplicate, tombstone and miss cases.
        write_table_size(3);
        add_req(OP_INSERT, 64'h61);
        add_req(OP_INSERT, 64'h61);
        add_req(OP_INSERT, 64'h62);
        add_req(OP_REMOVE, 64'h63);
        add_req(OP_LOOKUP, 64'h63);
        add_req(OP_LOOKUP, 64'h61);
        add_req(OP_REMOVE, 64'h61);
        add_req(OP_LOOKUP, 64'h61);
        add_req(OP_REMOVE, 64'h61);
        add_req(OP_REMOVE, 64'h61);
        add_req(OP_REMOVE, 64'h61);
        add_req(OP_INSERT, 64'h62);
        add_req(OP_LOOKUP, 64'h62);
        drain();

        // Random phases over several sizes and idling patterns.
        for (int p = 0; p < 7; p++) begin
            write_table_size(phase_sizes[p]);
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int n = 0; n < 200; n++)
                add_req(random_op(), random_key(phase_sizes[p] >= 1024 ? 26 : 4));
            // Long receiver hold-off while requests keep coming.
            if (p == 2) hold_count = 600;
            drain();
        end

        $display("Covered %0d requests and %0d checked results over sizes 0..2047,",
                 accepted_count, checked_count);
        $display("with full tables, tombstones, empty keys and mixed stall patterns.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
